### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GFV_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GFV_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### sv/gfv_pkg.sv
// ----------------------------------------------------------------------------
// GPS frame validator package
// Shared types, framing constants and the hex digit decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gfv_pkg;

  // Configured frame protocol.
  typedef enum logic [1:0] {
    PROTO_UBX  = 2'd0,
    PROTO_NMEA = 2'd1,
    PROTO_BIN  = 2'd2,
    PROTO_AUTO = 2'd3
  } proto_t;

  // Result codes reported with each closed frame.
  typedef enum logic [2:0] {
    RSN_OK           = 3'd0,
    RSN_LENGTH       = 3'd1,
    RSN_FRAMING      = 3'd2,
    RSN_LEN_MISMATCH = 3'd3,
    RSN_NO_STAR      = 3'd4,
    RSN_CHECKSUM     = 3'd5,
    RSN_PROTOCOL     = 3'd6
  } reason_t;

  // Fixed-width per-frame state, as seen after the current byte.
  typedef struct packed {
    logic [5:0][7:0] hdr;   // frame bytes 0 to 5
    logic [4:0][7:0] tail;  // last five bytes, entry 0 newest
    logic [7:0]      fa;    // Fletcher sum A
    logic [7:0]      fb;    // Fletcher sum B
    logic [15:0]     ws;    // wrapping word sum
    logic [5:0][7:0] xw;    // running XOR history, entry 0 newest
  } frame_view_t;

  localparam logic [7:0]  UBX_SYNC1    = 8'hB5;
  localparam logic [7:0]  UBX_SYNC2    = 8'h62;
  localparam logic [7:0]  BIN_START1   = 8'hA0;
  localparam logic [7:0]  BIN_START2   = 8'hA2;
  localparam logic [7:0]  BIN_END1     = 8'hB0;
  localparam logic [7:0]  BIN_END2     = 8'hB3;
  localparam logic [15:0] BIN_SUM_MASK = 16'h7FFF;
  localparam logic [7:0]  CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0]  CHAR_STAR    = 8'h2A;
  localparam int          FRAME_OVERHEAD = 8;
  localparam int          UBX_MIN_LEN  = 8;
  localparam int          NMEA_MIN_LEN = 10;
  localparam int          BIN_MIN_LEN  = 10;
  localparam logic [4:0]  HEX_NONE     = 5'd16;

  // Case-insensitive hex digit value; HEX_NONE for any other character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

### sv/gfv_accum.sv
// ----------------------------------------------------------------------------
// GPS frame validator accumulator
// Holds the running sums, windows and byte count of the frame in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfv_accum
  import gfv_pkg::*;
#(
  parameter  int MAX_BYTES = 1024,
  localparam int CNT_W     = $clog2(MAX_BYTES + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output logic [CNT_W-1:0] count_nxt_o,
  output frame_view_t      view_nxt_o
);

  logic [CNT_W-1:0] count_r, count_nxt;
  frame_view_t      view_r, view_nxt;

  // Fold the current word into the frame state.
  always_comb begin
    view_nxt  = view_r;
    count_nxt = count_r;
    for (int i = 0; i < 6; i++) begin
      if (count_r == CNT_W'(i)) begin
        view_nxt.hdr[i] = byte_i;
      end
    end
    view_nxt.tail[0] = byte_i;
    for (int k = 1; k < 5; k++) begin
      view_nxt.tail[k] = view_r.tail[k-1];
    end
    view_nxt.xw[0] = view_r.xw[0] ^ ((count_r != '0) ? byte_i : 8'h00);
    for (int k = 1; k < 6; k++) begin
      view_nxt.xw[k] = view_r.xw[k-1];
    end
    // The Fletcher sums lag two bytes behind, the word sum four.
    if (count_r >= CNT_W'(4)) begin
      view_nxt.fa = view_r.fa + view_r.tail[1];
      view_nxt.fb = view_r.fb + view_nxt.fa;
    end
    if (count_r >= CNT_W'(8)) begin
      view_nxt.ws = view_r.ws + {8'h00, view_r.tail[3]};
    end
    // Saturate one past the maximum so that long frames stay flagged.
    if (count_r <= CNT_W'(MAX_BYTES)) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // State register; a closing word returns everything to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      view_r  <= '0;
    end else if (adv_i) begin
      if (last_i) begin
        count_r <= '0;
        view_r  <= '0;
      end else begin
        count_r <= count_nxt;
        view_r  <= view_nxt;
      end
    end
  end

  assign count_nxt_o = count_nxt;
  assign view_nxt_o  = view_nxt;

endmodule

### sv/gfv_check.sv
// ----------------------------------------------------------------------------
// GPS frame validator checks
// Derives the result code of a frame from its state after the closing byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfv_check
  import gfv_pkg::*;
#(
  parameter  int MIN_BYTES = 8,
  parameter  int MAX_BYTES = 1024,
  localparam int CNT_W     = $clog2(MAX_BYTES + 2)
) (
  input  proto_t           proto_i,
  input  logic [CNT_W-1:0] count_i,
  input  frame_view_t      view_i,
  output reason_t          reason_o
);

  localparam int LW = (CNT_W > 17) ? CNT_W : 17;

  logic [LW-1:0]   n;
  logic [LW-1:0]   ubx_len;
  logic [LW-1:0]   bin_len;
  logic [4:0][4:0] hx;
  logic [4:0][7:0] star_val;
  logic            nmea_hit;
  logic            nmea_bad;
  reason_t         reason;

  assign n       = LW'(count_i);
  assign ubx_len = LW'({view_i.hdr[5], view_i.hdr[4]}) + LW'(FRAME_OVERHEAD);
  assign bin_len = LW'({view_i.hdr[2], view_i.hdr[3]}) + LW'(FRAME_OVERHEAD);

  // Expected NMEA checksum for each possible '*' position in the tail.
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      hx[j] = hex_value(view_i.tail[j]);
    end
    star_val[0] = 8'h00;
    star_val[1] = (hx[0] != HEX_NONE) ? {4'h0, hx[0][3:0]} : 8'h00;
    for (int k = 2; k < 5; k++) begin
      star_val[k] = 8'h00;
      if (hx[k-1] != HEX_NONE) begin
        star_val[k] = {4'h0, hx[k-1][3:0]};
        if (hx[k-2] != HEX_NONE) begin
          star_val[k] = {hx[k-1][3:0], hx[k-2][3:0]};
        end
      end
    end
  end

  // The earliest '*' in the tail wins, so the oldest entry is taken last.
  always_comb begin
    nmea_hit = 1'b0;
    nmea_bad = 1'b0;
    for (int k = 0; k < 5; k++) begin
      if (view_i.tail[k] == CHAR_STAR) begin
        nmea_hit = 1'b1;
        nmea_bad = (view_i.xw[k+1] != star_val[k]);
      end
    end
  end

  // Checks in order of precedence.
  always_comb begin
    priority if (n < LW'(MIN_BYTES) || n > LW'(MAX_BYTES)) begin
      reason = RSN_LENGTH;
    end else if (proto_i == PROTO_UBX) begin
      priority if (n < LW'(UBX_MIN_LEN)) begin
        reason = RSN_LENGTH;
      end else if (view_i.hdr[0] != UBX_SYNC1 || view_i.hdr[1] != UBX_SYNC2) begin
        reason = RSN_FRAMING;
      end else if (n != ubx_len) begin
        reason = RSN_LEN_MISMATCH;
      end else if (view_i.fa != view_i.tail[1] || view_i.fb != view_i.tail[0]) begin
        reason = RSN_CHECKSUM;
      end else begin
        reason = RSN_OK;
      end
    end else if (proto_i == PROTO_NMEA) begin
      priority if (n < LW'(NMEA_MIN_LEN)) begin
        reason = RSN_LENGTH;
      end else if (view_i.hdr[0] != CHAR_DOLLAR) begin
        reason = RSN_FRAMING;
      end else if (!nmea_hit) begin
        reason = RSN_NO_STAR;
      end else if (nmea_bad) begin
        reason = RSN_CHECKSUM;
      end else begin
        reason = RSN_OK;
      end
    end else if (proto_i == PROTO_BIN) begin
      priority if (n < LW'(BIN_MIN_LEN)) begin
        reason = RSN_LENGTH;
      end else if (view_i.hdr[0] != BIN_START1 || view_i.hdr[1] != BIN_START2 ||
                   view_i.tail[1] != BIN_END1 || view_i.tail[0] != BIN_END2) begin
        reason = RSN_FRAMING;
      end else if (n != bin_len) begin
        reason = RSN_LEN_MISMATCH;
      end else if ((view_i.ws & BIN_SUM_MASK) != {view_i.tail[3], view_i.tail[2]}) begin
        reason = RSN_CHECKSUM;
      end else begin
        reason = RSN_OK;
      end
    end else begin
      reason = RSN_PROTOCOL;
    end
  end

  assign reason_o = reason;

endmodule

### sv/gps_frame_validator.sv
// A closing byte accepted into the input register has its checks written to the result
// register when it advances; it waits there while a held result is stalled.
// Throughput: one byte per cycle; the state update and checks sit between the
// input register and the result register, so the only stall is a held result.
// Reset (rst_n low, synchronous) empties both registers, zeroes the frame state
// and selects the UBX protocol.
// ----------------------------------------------------------------------------
// GPS frame validator
// Checks UBX, NMEA and binary A0A2 frames byte by byte and reports per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gps_frame_validator
  import gfv_pkg::*;
#(
  parameter int MIN_BYTES = 8,
  parameter int MAX_BYTES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_frame_ok,
  output logic [2:0] out_fail_reason
);

  localparam int CNT_W = $clog2(MAX_BYTES + 2);

  proto_t           proto_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;
  logic             out_valid_r;
  logic             out_ok_r;
  reason_t          out_reason_r;
  logic             advance;
  logic             in_take;
  logic [CNT_W-1:0] count_nxt;
  frame_view_t      view_nxt;
  reason_t          reason;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r <= PROTO_UBX;
    end else if (cfg_wr_en) begin
      proto_r <= proto_t'(cfg_wdata);
    end
  end

  // A non-final word always moves on; a closing word needs the result slot.
  assign advance = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign s1_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
      s1_last_r <= in_frame_end;
    end
  end

  gfv_accum #(
    .MAX_BYTES (MAX_BYTES)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv_i       (advance),
    .byte_i      (s1_byte_r),
    .last_i      (s1_last_r),
    .count_nxt_o (count_nxt),
    .view_nxt_o  (view_nxt)
  );

  gfv_check #(
    .MIN_BYTES (MIN_BYTES),
    .MAX_BYTES (MAX_BYTES)
  ) u_check (
    .proto_i  (proto_r),
    .count_i  (count_nxt),
    .view_i   (view_nxt),
    .reason_o (reason)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (advance && s1_last_r) begin
      out_ok_r     <= (reason == RSN_OK);
      out_reason_r <= reason;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_ok    = out_ok_r;
  assign out_fail_reason = out_reason_r;

  // Checks on the block's own control.
  `GFV_ASSERT_IMPL(a_ok_matches_reason, out_valid, out_frame_ok == (out_fail_reason == RSN_OK), "frame_ok disagrees with fail_reason")
  `GFV_ASSERT_IMPL(a_stall_needs_word, in_stall, s1_valid_r && s1_last_r, "stall without a waiting closing word")
  `GFV_ASSERT_NEXT(a_close_gives_result, advance && s1_last_r, out_valid, "closing word gave no result")
  `GFV_ASSERT_NEXT(a_held_result_stable, out_valid && out_stall, $stable(out_fail_reason) && out_valid, "held result disturbed")

endmodule

### verif/gps_frame_validator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS frame validator testbench
// Feeds UBX, NMEA and A0A2 binary frames, well formed and damaged, a word at
// a time through the valid/stall channel, predicts each frame verdict with a
// local model of the validator and checks every verdict word as it leaves.
// ----------------------------------------------------------------------------

module gps_frame_validator_test;
  import gfv_pkg::*;

  localparam int MIN_BYTES     = 8;
  localparam int MAX_BYTES     = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_WORDS  = 150;

  // Ways in which a generated frame is damaged.
  typedef enum int {
    DEF_NONE,
    DEF_HEADER,
    DEF_TRAILER,
    DEF_LENGTH,
    DEF_CHECK,
    DEF_TRUNC
  } defect_t;

  // What follows the asterisk of an NMEA sentence.
  typedef enum int {
    TAIL_TWO,
    TAIL_ONE,
    TAIL_NONE,
    TAIL_BADCHAR
  } nmea_tail_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_word_t;

  typedef struct packed {
    logic    ok;
    reason_t why;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_frame_ok;
  logic [2:0] out_fail_reason;

  gps_frame_validator #(
    .MIN_BYTES(MIN_BYTES),
    .MAX_BYTES(MAX_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_ok   (out_frame_ok),
    .out_fail_reason(out_fail_reason)
  );

  always #5 clk = ~clk;

  // Words waiting to be driven and verdicts waiting to be seen.
  rx_word_t   pending_words[$];
  verdict_t   verdicts[$];
  logic [7:0] frame_buf[$];

  // Local copy of the validator state.
  proto_t      cur_proto = PROTO_UBX;
  int          frame_len;
  logic [7:0]  head_b[6];
  logic [7:0]  tail_b[5];
  logic [7:0]  xhist[6];
  logic [7:0]  fl_a;
  logic [7:0]  fl_b;
  logic [15:0] wsum;

  int mismatches = 0;
  int words_sent = 0;
  int frames_checked = 0;
  int settings_seen = 0;
  int random_words = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int calm_left = 0;
  int stall_left = 0;
  int open_left = 0;
  rx_word_t next_word;
  verdict_t want;

  task automatic clear_frame_state();
    int i;
    frame_len = 0;
    for (i = 0; i < 6; i++) begin
      head_b[i] = 8'd0;
      xhist[i] = 8'd0;
    end
    for (i = 0; i < 5; i++) tail_b[i] = 8'd0;
    fl_a = 8'd0;
    fl_b = 8'd0;
    wsum = 16'd0;
  endtask

  // Fold one accepted word into the model; a closing word yields a verdict.
  task automatic absorb_word(input logic [7:0] b, input logic last);
    int         i;
    int         pos;
    int         n;
    int         plen;
    int         star;
    int         ndig;
    int         nib;
    logic       stop;
    logic [7:0] c;
    logic [7:0] lc;
    logic [7:0] hexv;
    reason_t    why;
    verdict_t   v;
    pos = frame_len;
    if (pos < 6) head_b[pos] = b;
    for (i = 4; i > 0; i--) tail_b[i] = tail_b[i-1];
    tail_b[0] = b;
    for (i = 5; i > 0; i--) xhist[i] = xhist[i-1];
    xhist[0] = (pos >= 1) ? (xhist[1] ^ b) : xhist[1];
    if (pos >= 4) begin
      fl_a = fl_a + tail_b[2];
      fl_b = fl_b + fl_a;
    end
    if (pos >= 8) wsum = wsum + 16'(tail_b[4]);
    if (frame_len <= MAX_BYTES) frame_len++;
    if (last) begin
      n = frame_len;
      if (n < MIN_BYTES || n > MAX_BYTES) begin
        why = RSN_LENGTH;
      end else begin
        case (cur_proto)
          PROTO_UBX: begin
            plen = int'({head_b[5], head_b[4]});
            if (n < UBX_MIN_LEN) why = RSN_LENGTH;
            else if (head_b[0] != UBX_SYNC1 || head_b[1] != UBX_SYNC2) why = RSN_FRAMING;
            else if (n != plen + FRAME_OVERHEAD) why = RSN_LEN_MISMATCH;
            else if (fl_a != tail_b[1] || fl_b != tail_b[0]) why = RSN_CHECKSUM;
            else why = RSN_OK;
          end
          PROTO_NMEA: begin
            // The oldest asterisk in the tail window wins.
            star = -1;
            for (i = 4; i >= 0; i--) begin
              if (star < 0 && tail_b[i] == CHAR_STAR) star = i;
            end
            if (n < NMEA_MIN_LEN) begin
              why = RSN_LENGTH;
            end else if (head_b[0] != CHAR_DOLLAR) begin
              why = RSN_FRAMING;
            end else if (star < 0) begin
              why = RSN_NO_STAR;
            end else begin
              hexv = 8'd0;
              ndig = 0;
              stop = 1'b0;
              for (i = star - 1; i >= 0; i--) begin
                if (!stop && ndig < 2) begin
                  c = tail_b[i];
                  lc = c | 8'h20;
                  nib = -1;
                  if (c >= 8'h30 && c <= 8'h39) nib = int'(c) - 48;
                  else if (lc >= 8'h61 && lc <= 8'h66) nib = int'(lc) - 87;
                  if (nib < 0) begin
                    stop = 1'b1;
                  end else begin
                    hexv = {hexv[3:0], 4'(nib)};
                    ndig++;
                  end
                end
              end
              why = (xhist[star+1] == hexv) ? RSN_OK : RSN_CHECKSUM;
            end
          end
          PROTO_BIN: begin
            plen = int'({head_b[2], head_b[3]});
            if (n < BIN_MIN_LEN) why = RSN_LENGTH;
            else if (head_b[0] != BIN_START1 || head_b[1] != BIN_START2 ||
                     tail_b[1] != BIN_END1 || tail_b[0] != BIN_END2) why = RSN_FRAMING;
            else if (n != plen + FRAME_OVERHEAD) why = RSN_LEN_MISMATCH;
            else if ((wsum & BIN_SUM_MASK) != {tail_b[3], tail_b[2]}) why = RSN_CHECKSUM;
            else why = RSN_OK;
          end
          default: why = RSN_PROTOCOL;
        endcase
      end
      v.ok = (why == RSN_OK);
      v.why = why;
      verdicts.push_back(v);
      clear_frame_state();
    end
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (r < 55) g = 0;
    else if (r < 85) g = $urandom_range(1, 3);
    else if (r < 97) g = $urandom_range(4, 12);
    else g = $urandom_range(20, 60);
    return g;
  endfunction

  function automatic defect_t pick_defect();
    defect_t d;
    if ($urandom_range(0, 9) < 5) d = DEF_NONE;
    else d = defect_t'($urandom_range(1, 5));
    return d;
  endfunction

  // Hex digit in either case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = 8'h30 + 8'(v);
    else c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    return c;
  endfunction

  // Printable sentence character other than the asterisk.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == CHAR_STAR) c = 8'h2B;
    return c;
  endfunction

  task automatic build_ubx(input int plen, input defect_t d);
    int         i;
    int         k;
    logic [7:0] ca;
    logic [7:0] cb;
    frame_buf.delete();
    frame_buf.push_back(UBX_SYNC1);
    frame_buf.push_back(UBX_SYNC2);
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(8'(plen));
    frame_buf.push_back(8'(plen >> 8));
    repeat (plen) frame_buf.push_back(8'($urandom));
    ca = 8'd0;
    cb = 8'd0;
    for (i = 2; i < frame_buf.size(); i++) begin
      ca = ca + frame_buf[i];
      cb = cb + ca;
    end
    frame_buf.push_back(ca);
    frame_buf.push_back(cb);
    k = frame_buf.size() - 1 - int'($urandom_range(0, 1));
    case (d)
      DEF_HEADER: begin
        k = $urandom_range(0, 1);
        frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
      end
      DEF_LENGTH: begin
        k = $urandom_range(4, 5);
        frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
      end
      DEF_CHECK, DEF_TRAILER: frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
      DEF_TRUNC: repeat ($urandom_range(1, 3)) void'(frame_buf.pop_back());
      default: ;
    endcase
  endtask

  task automatic build_nmea(input int body_len, input nmea_tail_t style, input bit crlf,
                            input defect_t d);
    int         k;
    logic [7:0] c;
    logic [7:0] chk;
    frame_buf.delete();
    chk = 8'd0;
    frame_buf.push_back(CHAR_DOLLAR);
    repeat (body_len) begin
      c = text_char();
      chk = chk ^ c;
      frame_buf.push_back(c);
    end
    frame_buf.push_back(CHAR_STAR);
    case (style)
      TAIL_TWO: begin
        frame_buf.push_back(hex_char(chk[7:4]));
        frame_buf.push_back(hex_char(chk[3:0]));
      end
      TAIL_ONE: frame_buf.push_back(hex_char(chk[3:0]));
      TAIL_BADCHAR: frame_buf.push_back(8'h47 + 8'($urandom_range(0, 19)));
      default: ;
    endcase
    if (crlf) begin
      frame_buf.push_back(8'h0D);
      frame_buf.push_back(8'h0A);
    end
    case (d)
      DEF_HEADER: frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
      DEF_CHECK: begin
        if (body_len > 0) begin
          k = $urandom_range(1, body_len);
          frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
        end
      end
      DEF_TRAILER: frame_buf[body_len+1] = 8'h23;
      // Trailing junk pushes the asterisk out of the tail window.
      DEF_LENGTH: repeat ($urandom_range(4, 6)) frame_buf.push_back(text_char());
      DEF_TRUNC: repeat ($urandom_range(1, 2)) void'(frame_buf.pop_back());
      default: ;
    endcase
  endtask

  task automatic build_bin(input int plen, input defect_t d);
    int          k;
    logic [7:0]  c;
    logic [15:0] s;
    frame_buf.delete();
    frame_buf.push_back(BIN_START1);
    frame_buf.push_back(BIN_START2);
    frame_buf.push_back(8'(plen >> 8));
    frame_buf.push_back(8'(plen));
    s = 16'd0;
    repeat (plen) begin
      c = 8'($urandom);
      s = s + 16'(c);
      frame_buf.push_back(c);
    end
    s = s & BIN_SUM_MASK;
    frame_buf.push_back(s[15:8]);
    frame_buf.push_back(s[7:0]);
    frame_buf.push_back(BIN_END1);
    frame_buf.push_back(BIN_END2);
    case (d)
      DEF_HEADER: begin
        k = $urandom_range(0, 1);
        frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
      end
      DEF_TRAILER: begin
        k = frame_buf.size() - 1 - int'($urandom_range(0, 1));
        frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
      end
      DEF_LENGTH: begin
        k = $urandom_range(2, 3);
        frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
      end
      DEF_CHECK: begin
        // Either set the bit that the masked sum can never carry, or flip the low byte.
        k = frame_buf.size() - 4;
        if ($urandom_range(0, 1)) frame_buf[k] = frame_buf[k] | 8'h80;
        else frame_buf[k+1] = frame_buf[k+1] ^ 8'($urandom_range(1, 255));
      end
      DEF_TRUNC: repeat ($urandom_range(1, 3)) void'(frame_buf.pop_back());
      default: ;
    endcase
  endtask

  task automatic build_noise(input int len);
    int i;
    frame_buf.delete();
    for (i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    // Now and then start the noise with a plausible header.
    if (len >= 2 && $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          frame_buf[0] = UBX_SYNC1;
          frame_buf[1] = UBX_SYNC2;
        end
        1: frame_buf[0] = CHAR_DOLLAR;
        default: begin
          frame_buf[0] = BIN_START1;
          frame_buf[1] = BIN_START2;
        end
      endcase
    end
  endtask

  task automatic queue_word(input logic [7:0] b, input logic last);
    rx_word_t w;
    w.data = b;
    w.last = last;
    pending_words.push_back(w);
  endtask

  task automatic queue_frame();
    int i;
    for (i = 0; i < frame_buf.size(); i++) queue_word(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic random_frame(input proto_t p);
    int      pick;
    proto_t  kind;
    defect_t d;
    pick = $urandom_range(0, 99);
    kind = (p == PROTO_AUTO || pick >= 70) ? proto_t'($urandom_range(0, 2)) : p;
    d = pick_defect();
    if (pick >= 85) begin
      build_noise($urandom_range(1, 24));
    end else begin
      case (kind)
        PROTO_UBX: build_ubx(($urandom_range(0, 4) == 0) ? int'($urandom_range(25, 120)) :
                             int'($urandom_range(0, 24)), d);
        PROTO_NMEA: build_nmea($urandom_range(0, 40),
                               ($urandom_range(0, 9) < 7) ? TAIL_TWO :
                               nmea_tail_t'($urandom_range(1, 3)),
                               $urandom_range(0, 1), d);
        default: build_bin($urandom_range(0, 40), d);
      endcase
    end
    queue_frame();
    random_words += frame_buf.size();
  endtask

  // Wait until every word has gone in and every verdict has come out.
  task automatic wait_quiet();
    while (pending_words.size() != 0 || in_valid || verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_protocol(input proto_t p);
    wait_quiet();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    settings_seen++;
  endtask

  // Driver: presents queued words, holds them while stalled, idles at random.
  always @(posedge clk) begin
    if (cfg_wr_en) cur_proto = proto_t'(cfg_wdata);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_word(in_rx_byte, in_frame_end);
        words_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= next_word.data;
          in_frame_end <= next_word.last;
          if (calm_left > 0) begin
            calm_left--;
            gap_left = 0;
          end else begin
            gap_left = pick_gap();
            if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(30, 120);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each verdict word with the oldest prediction and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        frames_checked++;
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual ok=%0b reason=%0d",
                   $time, out_frame_ok, out_fail_reason);
          mismatches++;
        end else begin
          want = verdicts.pop_front();
          if (out_frame_ok !== want.ok) begin
            $display("%0t: frame_ok mismatch, expected %0b, actual %0b",
                     $time, want.ok, out_frame_ok);
            mismatches++;
          end
          if (out_fail_reason !== 3'(want.why)) begin
            $display("%0t: fail_reason mismatch, expected %0d, actual %0d",
                     $time, 3'(want.why), out_fail_reason);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (open_left > 0) open_left--;
        else if ($urandom_range(0, 399) == 0) open_left = $urandom_range(40, 150);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, verdicts.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    proto_t p;
    int     i;
    clear_frame_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // UBX: shortest valid frame, a normal one, each defect, runt frames.
    set_protocol(PROTO_UBX);
    build_ubx(0, DEF_NONE);   queue_frame();
    build_ubx(5, DEF_NONE);   queue_frame();
    build_ubx(3, DEF_HEADER); queue_frame();
    build_ubx(3, DEF_LENGTH); queue_frame();
    build_ubx(3, DEF_CHECK);  queue_frame();
    build_noise(1);           queue_frame();
    build_noise(7);           queue_frame();

    // NMEA: with and without line end, short and missing digits, bad digit,
    // no asterisk, bad start, and a sentence below the protocol minimum.
    set_protocol(PROTO_NMEA);
    build_nmea(8, TAIL_TWO, 1, DEF_NONE);     queue_frame();
    build_nmea(8, TAIL_TWO, 0, DEF_NONE);     queue_frame();
    build_nmea(8, TAIL_ONE, 1, DEF_NONE);     queue_frame();
    build_nmea(8, TAIL_NONE, 1, DEF_NONE);    queue_frame();
    build_nmea(8, TAIL_BADCHAR, 1, DEF_NONE); queue_frame();
    build_nmea(8, TAIL_TWO, 1, DEF_TRAILER);  queue_frame();
    build_nmea(8, TAIL_TWO, 1, DEF_HEADER);   queue_frame();
    build_nmea(4, TAIL_TWO, 0, DEF_NONE);     queue_frame();

    // Binary: shortest valid frame, each defect, one below its minimum.
    set_protocol(PROTO_BIN);
    build_bin(2, DEF_NONE);    queue_frame();
    build_bin(2, DEF_HEADER);  queue_frame();
    build_bin(2, DEF_TRAILER); queue_frame();
    build_bin(2, DEF_LENGTH);  queue_frame();
    build_bin(2, DEF_CHECK);   queue_frame();
    build_bin(1, DEF_NONE);    queue_frame();

    // Auto setting rejects an otherwise valid frame.
    set_protocol(PROTO_AUTO);
    build_ubx(4, DEF_NONE); queue_frame();

    // The protocol is only sampled on the closing word.
    set_protocol(PROTO_UBX);
    build_ubx(6, DEF_NONE);
    for (i = 0; i < frame_buf.size() - 1; i++) queue_word(frame_buf[i], 1'b0);
    set_protocol(PROTO_NMEA);
    queue_word(frame_buf[$], 1'b1);

    // Random phases, each under one protocol setting; some phases begin with
    // a frame left open across the register write.
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 5) == 0) begin
        build_noise($urandom_range(1, 6));
        for (i = 0; i < frame_buf.size(); i++) queue_word(frame_buf[i], 1'b0);
        random_words += frame_buf.size();
      end
      p = proto_t'($urandom_range(0, 3));
      set_protocol(p);
      repeat ($urandom_range(3, 10)) random_frame(p);
    end

    // Length limit: a well formed frame two words past the maximum saturates
    // the count and is still flagged as too long.
    set_protocol(PROTO_UBX);
    build_ubx(MAX_BYTES - FRAME_OVERHEAD + 2, DEF_NONE); queue_frame();

    wait_quiet();
    $display("Run covered %0d words and %0d frame verdicts under %0d protocol settings.",
             words_sent, frames_checked, settings_seen);
    $display("Frames spanned UBX, NMEA and binary layouts, damaged frames and length limits.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
